// ----- design/tsr_pkg.sv -----
// Shared types, codes and helpers for the TCP stream reassembly block.
`default_nettype none
package tsr_pkg;

  localparam int FragSlotsDefault = 16;
  localparam int MaxResults       = 36;

  // Result kinds
  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_DATA   = 2'd1;
  localparam logic [1:0] RK_START  = 2'd2;
  localparam logic [1:0] RK_CLOSE  = 2'd3;

  // Status codes
  localparam logic [3:0] ST_HANDLED  = 4'd0;
  localparam logic [3:0] ST_NON_IP   = 4'd1;
  localparam logic [3:0] ST_NON_TCP  = 4'd2;
  localparam logic [3:0] ST_NO_DATA  = 4'd3;
  localparam logic [3:0] ST_NO_MEM   = 4'd4;
  localparam logic [3:0] ST_CLOSED   = 4'd5;
  localparam logic [3:0] ST_NO_MATCH = 4'd6;
  localparam logic [3:0] ST_FIN_RST  = 4'd7;
  localparam logic [3:0] ST_RETRANS  = 4'd8;
  localparam logic [3:0] ST_BUFFERED = 4'd9;

  // Packet kinds
  localparam logic [1:0] PK_TCP     = 2'd0;
  localparam logic [1:0] PK_NON_TCP = 2'd2;

  // Close reasons
  localparam logic RSN_FIN_RST = 1'b0;
  localparam logic RSN_MANUAL  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_CLEAR_ON_SWITCH = 1'b0;
  localparam logic CFG_MAX_OOO         = 1'b1;

  typedef enum logic [1:0] {
    MODE_SCAN  = 2'd0,
    MODE_FORCE = 2'd1,
    MODE_FIND  = 2'd2
  } frag_mode_t;

  typedef struct packed {
    logic       start;
    frag_mode_t mode;
    logic       side;
    logic       clear_all;
    logic       inv_best;
    logic       write;
  } frag_cmd_t;

  typedef struct packed {
    logic done;
    logic best_ok;
    logic slot_ok;
    logic match;
  } frag_stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        side;
    logic        from_frag;
    logic [3:0]  slot;
    logic [15:0] off;
    logic [15:0] cnt;
    logic [31:0] miss;
    logic [3:0]  status;
    logic        reason;
    logic        last;
  } result_t;

  // a - b taken modulo 2^32, compared against zero serially
  function automatic logic ser_le0(input logic [31:0] d);
    return (d == 32'd0) || d[31];
  endfunction

  function automatic logic ser_gt0(input logic [31:0] d);
    return (d != 32'd0) && !d[31];
  endfunction

endpackage
`default_nettype wire

// ----- design/tsr_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tsr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/tsr_frag.sv -----
// Fragment table: valid bits, slot store and the shared slot evaluation unit.
`default_nettype none
module tsr_frag import tsr_pkg::*; #(
  parameter int SLOTS = FragSlotsDefault,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  frag_cmd_t   cmd,
  input  logic [31:0] e_in,
  input  logic [31:0] key,
  input  logic [31:0] wr_seq,
  input  logic [15:0] wr_len,
  output frag_stat_t  stat,
  output logic [IW-1:0] best_idx,
  output logic [31:0] best_d,
  output logic [31:0] best_seq,
  output logic [15:0] best_len,
  output logic [IW:0] count
);

  localparam int AW = $clog2(2 * SLOTS);

  logic [2*SLOTS-1:0] valid;
  logic               run;
  logic               done;
  logic               pass_side;
  frag_mode_t         pass_mode;
  logic [31:0]        pass_e;
  logic [31:0]        pass_key;
  logic [IW:0]        iss;
  logic               proc_en;
  logic               proc_vld;
  logic [IW-1:0]      proc_idx;
  logic               best_ok;
  logic               match;
  logic [IW-1:0]      match_idx;
  logic               free_ok;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      slot_idx;
  logic [47:0]        rdata;
  logic [31:0]        rd_seq;
  logic [15:0]        rd_len;
  logic               issue;
  logic [IW-1:0]      iss_idx;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               live;
  logic               drop;
  logic               cand;
  logic [31:0]        cand_d;
  logic [31:0]        end_d;
  logic [31:0]        ahead;
  logic [31:0]        back;

  function automatic logic [AW-1:0] slot_addr(input logic s, input logic [IW-1:0] i);
    return s ? (AW'(SLOTS) + AW'(i)) : AW'(i);
  endfunction

  assign issue    = run && (iss != (IW+1)'(SLOTS));
  assign iss_idx  = iss[IW-1:0];
  assign raddr    = slot_addr(pass_side, iss_idx);
  assign slot_idx = match ? match_idx : free_idx;
  assign waddr    = slot_addr(cmd.side, slot_idx);
  assign rd_seq   = rdata[47:16];
  assign rd_len   = rdata[15:0];

  tsr_ram #(.WIDTH(48), .DEPTH(2 * SLOTS)) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (waddr),
    .wdata ({wr_seq, wr_len}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Slot evaluation: one slot per cycle
  always_comb begin
    live   = proc_en && proc_vld;
    end_d  = rd_seq + {16'd0, rd_len} - pass_e;
    ahead  = rd_seq - pass_e;
    back   = pass_e - rd_seq;
    drop   = 1'b0;
    cand   = 1'b0;
    cand_d = back;
    unique case (pass_mode)
      MODE_SCAN: begin
        drop   = live && ser_le0(end_d);
        cand   = live && !drop && ser_le0(ahead) && (!best_ok || back > best_d);
        cand_d = back;
      end
      MODE_FORCE: begin
        cand   = live && (!best_ok || ahead < best_d);
        cand_d = ahead;
      end
      default: begin
        cand = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      done    <= 1'b0;
      proc_en <= 1'b0;
      valid   <= '0;
      best_ok <= 1'b0;
      match   <= 1'b0;
      free_ok <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        run       <= 1'b1;
        iss       <= '0;
        proc_en   <= 1'b0;
        best_ok   <= 1'b0;
        match     <= 1'b0;
        free_ok   <= 1'b0;
        count     <= '0;
        pass_side <= cmd.side;
        pass_mode <= cmd.mode;
        pass_e    <= e_in;
        pass_key  <= key;
      end else begin
        if (issue) begin
          iss      <= iss + 1'b1;
          proc_en  <= 1'b1;
          proc_idx <= iss_idx;
          proc_vld <= valid[raddr];
        end else if (run) begin
          run     <= 1'b0;
          proc_en <= 1'b0;
          done    <= 1'b1;
        end
        if (live && !drop) begin
          count <= count + 1'b1;
        end
        if (cand) begin
          best_ok  <= 1'b1;
          best_idx <= proc_idx;
          best_d   <= cand_d;
          best_seq <= rd_seq;
          best_len <= rd_len;
        end
        if (pass_mode == MODE_FIND && live && !match && rd_seq == pass_key) begin
          match     <= 1'b1;
          match_idx <= proc_idx;
        end
        if (pass_mode == MODE_FIND && proc_en && !proc_vld && !free_ok) begin
          free_ok  <= 1'b1;
          free_idx <= proc_idx;
        end
      end
      if (cmd.clear_all) begin
        valid <= '0;
      end else begin
        if (drop) begin
          valid[slot_addr(pass_side, proc_idx)] <= 1'b0;
        end
        if (cmd.inv_best) begin
          valid[slot_addr(pass_side, best_idx)] <= 1'b0;
        end
        if (cmd.write) begin
          valid[waddr] <= 1'b1;
        end
      end
    end
  end

  assign stat.done    = done;
  assign stat.best_ok = best_ok;
  assign stat.slot_ok = match || free_ok;
  assign stat.match   = match;

endmodule
`default_nettype wire

// ----- design/tcp_stream_reassembly_top.sv -----
// Top level: TCP stream reassembly sequencer, connection state and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  cfg      | cfg_write            | cfg_index, cfg_data
//  in       | in_valid / in_ready  | operation .. rst_flag (segment descriptor)
//  out      | out_valid / out_ready| result_kind .. last (one result each)
//
// One transaction in at a time; in_ready is high only while the sequencer idles.
// A segment runs through the sequencer states after acceptance (one more state when it opens
// the connection), plus one pass over all FRAG_SLOTS slots per slot lookup, fragment count
// pass, delivery scan or forced gap pass; a status-only transaction goes from dispatch to status.
// Each pass reads one slot per cycle from the single fragment RAM read port.
// Results leave through one output register; the sequencer holds while it is full.
// Reset is synchronous and clears the connection, the fragment valid bits and config.
`default_nettype none
module tcp_stream_reassembly_top import tsr_pkg::*; #(
  parameter int FRAG_SLOTS = FragSlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [1:0]  packet_kind,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] segment_seq,
  input  logic [15:0] payload_length,
  input  logic        syn_flag,
  input  logic        fin_flag,
  input  logic        rst_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic        side,
  output logic        from_fragment,
  output logic [3:0]  slot_index,
  output logic [15:0] byte_offset,
  output logic [15:0] byte_count,
  output logic [31:0] missing_bytes,
  output logic [3:0]  status_code,
  output logic        close_reason,
  output logic        last
);

  localparam int IW = (FRAG_SLOTS > 1) ? $clog2(FRAG_SLOTS) : 1;

  typedef enum logic [23:0] {
    S_IDLE   = 24'h000001,
    S_DISP   = 24'h000002,
    S_START  = 24'h000004,
    S_IDENT  = 24'h000008,
    S_CHK1   = 24'h000010,
    S_CNT    = 24'h000020,
    S_CNTW   = 24'h000040,
    S_SW     = 24'h000080,
    S_TAIL   = 24'h000100,
    S_FIND   = 24'h000200,
    S_FINDW  = 24'h000400,
    S_STORE  = 24'h000800,
    S_FINRST = 24'h001000,
    S_FR2    = 24'h002000,
    S_CLOSE  = 24'h004000,
    S_CL1    = 24'h008000,
    S_CL2    = 24'h010000,
    S_STATUS = 24'h020000,
    S_CKS    = 24'h040000,
    S_CKSW   = 24'h080000,
    S_CKSE   = 24'h100000,
    S_CKF    = 24'h200000,
    S_CKFW   = 24'h400000,
    S_CKFE   = 24'h800000
  } state_t;

  state_t      state;
  state_t      ck_ret;
  logic        ck_side;
  logic        ck_clean;
  logic        find_retry;
  logic        fr_side;
  logic        fr_rst;
  logic        reason_r;
  logic [3:0]  st_r;

  logic        conn_open;
  logic [1:0]  sides_known;
  logic [31:0] side_addr [2];
  logic [15:0] side_prt [2];
  logic [31:0] exp_seq [2];
  logic [1:0]  finished;
  logic        prev_ok;
  logic        prev_s;
  logic        cur_side;
  logic        first_r;

  logic        op_r;
  logic [1:0]  kind_r;
  logic [31:0] addr_r;
  logic [15:0] port_r;
  logic [31:0] seq_r;
  logic [15:0] len_r;
  logic        syn_r;
  logic        fin_r;
  logic        rstf_r;

  logic        clear_on_switch;
  logic [4:0]  max_ooo;
  logic [5:0]  res_n;
  result_t     res_q;

  frag_cmd_t   fcmd;
  frag_stat_t  fstat;
  logic [IW-1:0] best_idx;
  logic [31:0] best_d;
  logic [31:0] best_seq;
  logic [15:0] best_len;
  logic [IW:0] fcount;
  logic [31:0] e_ck;

  logic        can_emit;
  logic        emit_req;
  result_t     er;
  logic        finrst;
  logic [31:0] e_s;
  logic [31:0] seq_end;
  logic        late;
  logic [31:0] skip;
  logic        partial;
  logic        m0;
  logic        m1;

  assign in_ready = (state == S_IDLE);
  assign can_emit = !out_valid || out_ready;
  assign finrst   = fin_r || rstf_r;
  assign e_s      = exp_seq[cur_side];
  assign e_ck     = exp_seq[ck_side];
  assign seq_end  = seq_r + {16'd0, len_r};
  assign late     = (seq_r - e_s) >= 32'h8000_0000;
  assign skip     = e_s - seq_r;
  assign partial  = late && ser_gt0(seq_end - e_s);
  assign m0       = (side_addr[0] == addr_r) && (side_prt[0] == port_r);
  assign m1       = (side_addr[1] == addr_r) && (side_prt[1] == port_r);

  // Fragment table commands
  always_comb begin
    fcmd.start     = (state == S_CKS) || (state == S_CKF) || (state == S_FIND) ||
                     (state == S_CNT);
    fcmd.mode      = (state == S_CKS) ? MODE_SCAN : (state == S_CKF) ? MODE_FORCE : MODE_FIND;
    fcmd.side      = (state == S_CNT) ? prev_s :
                     ((state == S_FIND) || (state == S_STORE)) ? cur_side : ck_side;
    fcmd.clear_all = ((state == S_START) || (state == S_CL2)) && can_emit;
    fcmd.inv_best  = (((state == S_CKSE) && fstat.best_ok) || (state == S_CKFE)) && can_emit;
    fcmd.write     = (state == S_STORE);
  end

  tsr_frag #(.SLOTS(FRAG_SLOTS)) u_frag (
    .clk      (clk),
    .rst      (rst),
    .cmd      (fcmd),
    .e_in     (e_ck),
    .key      (seq_r),
    .wr_seq   (seq_r),
    .wr_len   (len_r),
    .stat     (fstat),
    .best_idx (best_idx),
    .best_d   (best_d),
    .best_seq (best_seq),
    .best_len (best_len),
    .count    (fcount)
  );

  // Result to load in the current state
  always_comb begin
    emit_req = 1'b0;
    er       = '0;
    unique case (state)
      S_START: begin
        emit_req = 1'b1;
        er.kind  = RK_START;
      end
      S_SW: begin
        er.kind = RK_DATA;
        er.side = cur_side;
        er.cnt  = len_r;
        if (first_r) begin
          emit_req = (len_r != 16'd0);
        end else if (late) begin
          emit_req = partial;
          er.off   = skip[15:0];
          er.cnt   = len_r - skip[15:0];
        end else if (len_r != 16'd0 && seq_r == e_s) begin
          emit_req = 1'b1;
        end
      end
      S_CKSE: begin
        emit_req     = fstat.best_ok;
        er.kind      = RK_DATA;
        er.side      = ck_side;
        er.from_frag = 1'b1;
        er.slot      = 4'(best_idx);
        er.off       = best_d[15:0];
        er.cnt       = best_len - best_d[15:0];
      end
      S_CKFE: begin
        emit_req     = 1'b1;
        er.kind      = RK_DATA;
        er.side      = ck_side;
        er.from_frag = 1'b1;
        er.slot      = 4'(best_idx);
        er.cnt       = best_len;
        er.miss      = best_d;
      end
      S_CL2: begin
        emit_req  = 1'b1;
        er.kind   = RK_CLOSE;
        er.reason = reason_r;
      end
      S_STATUS: begin
        emit_req  = 1'b1;
        er.kind   = RK_STATUS;
        er.status = st_r;
        er.last   = 1'b1;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_on_switch <= 1'b0;
      max_ooo         <= 5'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CLEAR_ON_SWITCH: clear_on_switch <= cfg_data[0];
        CFG_MAX_OOO:         max_ooo <= cfg_data;
        default:             max_ooo <= max_ooo;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      res_n     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        res_n <= '0;
      end else if (emit_req && can_emit && res_n < 6'(MaxResults)) begin
        res_q     <= er;
        out_valid <= 1'b1;
        res_n     <= res_n + 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      conn_open   <= 1'b0;
      sides_known <= 2'd0;
      finished    <= 2'b00;
      prev_ok     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= operation;
            kind_r <= packet_kind;
            addr_r <= source_address;
            port_r <= source_port;
            seq_r  <= segment_seq;
            len_r  <= payload_length;
            syn_r  <= syn_flag;
            fin_r  <= fin_flag;
            rstf_r <= rst_flag;
            state  <= S_DISP;
          end
        end
        S_DISP: begin
          if (op_r) begin
            reason_r <= RSN_MANUAL;
            st_r     <= ST_HANDLED;
            state    <= S_CLOSE;
          end else if (kind_r == PK_NON_TCP) begin
            st_r  <= ST_NON_TCP;
            state <= S_STATUS;
          end else if (kind_r != PK_TCP) begin
            st_r  <= ST_NON_IP;
            state <= S_STATUS;
          end else if (len_r == 16'd0 && !syn_r && !finrst) begin
            st_r  <= ST_NO_DATA;
            state <= S_STATUS;
          end else if (!conn_open) begin
            state <= S_START;
          end else begin
            state <= S_IDENT;
          end
        end
        S_START: begin
          if (can_emit) begin
            conn_open   <= 1'b1;
            sides_known <= 2'd0;
            finished    <= 2'b00;
            prev_ok     <= 1'b0;
            state       <= S_IDENT;
          end
        end
        S_IDENT: begin
          state <= S_CHK1;
          if (sides_known == 2'd0) begin
            cur_side     <= 1'b0;
            side_addr[0] <= addr_r;
            side_prt[0]  <= port_r;
            sides_known  <= 2'd1;
            first_r      <= 1'b1;
          end else if (m0) begin
            cur_side <= 1'b0;
            first_r  <= 1'b0;
          end else if (sides_known == 2'd1) begin
            cur_side     <= 1'b1;
            side_addr[1] <= addr_r;
            side_prt[1]  <= port_r;
            sides_known  <= 2'd2;
            first_r      <= 1'b1;
          end else if (m1) begin
            cur_side <= 1'b1;
            first_r  <= 1'b0;
          end else begin
            st_r  <= ST_NO_MATCH;
            state <= S_STATUS;
          end
        end
        S_CHK1: begin
          if (finished[cur_side]) begin
            if (!finished[!cur_side] && rstf_r) begin
              st_r    <= ST_FIN_RST;
              fr_side <= !cur_side;
              fr_rst  <= 1'b1;
              state   <= S_FINRST;
            end else begin
              st_r  <= ST_CLOSED;
              state <= S_STATUS;
            end
          end else if (finrst && len_r == 16'd0) begin
            st_r    <= ST_FIN_RST;
            fr_side <= cur_side;
            fr_rst  <= rstf_r;
            state   <= S_FINRST;
          end else if (clear_on_switch && !first_r && len_r != 16'd0 && prev_ok &&
                       prev_s != cur_side) begin
            state <= S_CNT;
          end else begin
            state <= S_SW;
          end
        end
        S_CNT: begin
          state <= S_CNTW;
        end
        S_CNTW: begin
          if (fstat.done) begin
            if (fcount != '0) begin
              ck_side  <= prev_s;
              ck_clean <= 1'b1;
              ck_ret   <= S_SW;
              state    <= S_CKS;
            end else begin
              state <= S_SW;
            end
          end
        end
        S_SW: begin
          if (can_emit) begin
            prev_ok <= 1'b1;
            prev_s  <= cur_side;
            state   <= S_TAIL;
            if (first_r) begin
              exp_seq[cur_side] <= seq_end + {31'd0, syn_r};
              st_r <= ST_HANDLED;
            end else if (late) begin
              if (partial) begin
                exp_seq[cur_side] <= seq_end;
                st_r <= ST_HANDLED;
              end else begin
                st_r <= ST_RETRANS;
              end
            end else if (len_r == 16'd0) begin
              st_r <= finrst ? ST_FIN_RST : ST_NO_DATA;
            end else if (seq_r == e_s) begin
              exp_seq[cur_side] <= seq_end + {31'd0, syn_r};
              st_r     <= ST_HANDLED;
              ck_side  <= cur_side;
              ck_clean <= 1'b0;
              ck_ret   <= S_TAIL;
              state    <= S_CKS;
            end else begin
              find_retry <= 1'b0;
              state      <= S_FIND;
            end
          end
        end
        S_TAIL: begin
          if (finrst) begin
            fr_side <= cur_side;
            fr_rst  <= rstf_r;
            state   <= S_FINRST;
          end else begin
            state <= S_STATUS;
          end
        end
        S_FIND: begin
          state <= S_FINDW;
        end
        S_FINDW: begin
          if (fstat.done) begin
            if (fstat.slot_ok) begin
              state <= S_STORE;
            end else if (!find_retry) begin
              find_retry <= 1'b1;
              ck_side    <= cur_side;
              ck_clean   <= 1'b1;
              ck_ret     <= S_FIND;
              state      <= S_CKS;
            end else begin
              st_r  <= ST_NO_MEM;
              state <= S_STATUS;
            end
          end
        end
        S_STORE: begin
          st_r <= ST_BUFFERED;
          // count after the store: a new slot adds one, an overwrite does not
          if (max_ooo != 5'd0 &&
              (int'(fcount) + (fstat.match ? 0 : 1)) > int'(max_ooo)) begin
            ck_side  <= cur_side;
            ck_clean <= 1'b0;
            ck_ret   <= S_TAIL;
            state    <= S_CKS;
          end else begin
            state <= S_TAIL;
          end
        end
        S_FINRST: begin
          if (finished[fr_side]) begin
            state <= S_STATUS;
          end else begin
            finished[fr_side] <= 1'b1;
            if (finished[!fr_side]) begin
              reason_r <= RSN_FIN_RST;
              state    <= S_CLOSE;
            end else begin
              ck_side  <= fr_side;
              ck_clean <= 1'b1;
              ck_ret   <= S_FR2;
              state    <= S_CKS;
            end
          end
        end
        S_FR2: begin
          if (fr_rst) begin
            reason_r <= RSN_FIN_RST;
            state    <= S_CLOSE;
          end else begin
            state <= S_STATUS;
          end
        end
        S_CLOSE: begin
          if (!conn_open) begin
            state <= S_STATUS;
          end else begin
            ck_side  <= 1'b0;
            ck_clean <= 1'b1;
            ck_ret   <= S_CL1;
            state    <= S_CKS;
          end
        end
        S_CL1: begin
          ck_side  <= 1'b1;
          ck_clean <= 1'b1;
          ck_ret   <= S_CL2;
          state    <= S_CKS;
        end
        S_CL2: begin
          if (can_emit) begin
            conn_open   <= 1'b0;
            sides_known <= 2'd0;
            finished    <= 2'b00;
            prev_ok     <= 1'b0;
            state       <= S_STATUS;
          end
        end
        S_STATUS: begin
          if (can_emit) begin
            state <= S_IDLE;
          end
        end
        S_CKS: begin
          state <= S_CKSW;
        end
        S_CKSW: begin
          if (fstat.done) begin
            state <= S_CKSE;
          end
        end
        S_CKSE: begin
          if (fstat.best_ok) begin
            // deliver the fragment covering the expected sequence, then rescan
            if (can_emit) begin
              exp_seq[ck_side] <= e_ck + ({16'd0, best_len} - best_d);
              state <= S_CKS;
            end
          end else if (ck_clean && fcount != '0) begin
            state <= S_CKF;
          end else if (!ck_clean && max_ooo != 5'd0 && int'(fcount) > int'(max_ooo)) begin
            ck_clean <= 1'b1;
            state    <= S_CKF;
          end else begin
            state <= ck_ret;
          end
        end
        S_CKF: begin
          state <= S_CKFW;
        end
        S_CKFW: begin
          if (fstat.done) begin
            state <= S_CKFE;
          end
        end
        S_CKFE: begin
          // force the gap: jump to the nearest fragment ahead
          if (can_emit) begin
            exp_seq[ck_side] <= best_seq + {16'd0, best_len};
            state <= S_CKS;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_kind   = res_q.kind;
  assign side          = res_q.side;
  assign from_fragment = res_q.from_frag;
  assign slot_index    = res_q.slot;
  assign byte_offset   = res_q.off;
  assign byte_count    = res_q.cnt;
  assign missing_bytes = res_q.miss;
  assign status_code   = res_q.status;
  assign close_reason  = res_q.reason;
  assign last          = res_q.last;

endmodule
`default_nettype wire

// ----- verif/tsr_checker.sv -----
// Checker for the TCP stream reassembly block: predicts results and compares them.
`timescale 1ns / 100ps
module tsr_checker import tsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [1:0]  packet_kind,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] segment_seq,
  input  logic [15:0] payload_length,
  input  logic        syn_flag,
  input  logic        fin_flag,
  input  logic        rst_flag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  result_kind,
  input  logic        side,
  input  logic        from_fragment,
  input  logic [3:0]  slot_index,
  input  logic [15:0] byte_offset,
  input  logic [15:0] byte_count,
  input  logic [31:0] missing_bytes,
  input  logic [3:0]  status_code,
  input  logic        close_reason,
  input  logic        last,
  output int          failures,
  output int          pending,
  output int          results_seen
);

  localparam int Slots = FragSlotsDefault;
  localparam int NoSide = 2;

  // predictor copy of the connection
  bit          clear_on_switch;
  bit [4:0]    ooo_limit;
  bit          conn_open;
  int          sides_seen;
  bit [31:0]   peer_addr[2];
  bit [15:0]   peer_port[2];
  bit [31:0]   next_seq[2];
  bit          side_done[2];
  int          last_side;
  bit          frag_used[2*Slots];
  bit [31:0]   frag_start[2*Slots];
  bit [15:0]   frag_len[2*Slots];

  result_t     expected_results[$];
  int          emitted;

  function automatic bit not_after(bit [31:0] d);
    return (d == 32'd0) || d[31];
  endfunction

  function automatic void put(bit [1:0] k, bit sd, bit ff, bit [3:0] sl, bit [15:0] off,
                              bit [15:0] cnt, bit [31:0] miss, bit [3:0] st, bit rs,
                              bit lst);
    result_t r;
    if (emitted >= MaxResults) return;
    r.kind = k; r.side = sd; r.from_frag = ff; r.slot = sl; r.off = off; r.cnt = cnt;
    r.miss = miss; r.status = st; r.reason = rs; r.last = lst;
    expected_results.push_back(r);
    emitted++;
  endfunction

  function automatic int frags_held(int s);
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) if (frag_used[s*Slots+i]) n++;
    return n;
  endfunction

  // deliver every fragment that now covers the expected sequence
  function automatic void deliver_ready(int s);
    while (1) begin
      bit [31:0] e, d, bestd, cnt, fend;
      int best, k;
      e = next_seq[s];
      best = -1;
      bestd = 0;
      for (int i = 0; i < Slots; i++) begin
        k = s*Slots + i;
        if (frag_used[k]) begin
          fend = frag_start[k] + frag_len[k];
          if (not_after(fend - e)) frag_used[k] = 0;
          else if (not_after(frag_start[k] - e)) begin
            d = e - frag_start[k];
            if (best < 0 || d > bestd) begin
              best = i;
              bestd = d;
            end
          end
        end
      end
      if (best < 0) break;
      k = s*Slots + best;
      cnt = frag_len[k] - bestd;
      put(RK_DATA, s[0], 1, best[3:0], bestd[15:0], cnt[15:0], 0, ST_HANDLED, 0, 0);
      next_seq[s] = e + cnt;
      frag_used[k] = 0;
    end
  endfunction

  function automatic void settle_side(int s, bit clean);
    while (1) begin
      int n, best, k;
      bit [31:0] e, d, bestd;
      deliver_ready(s);
      n = frags_held(s);
      if (clean && n > 0) begin
        e = next_seq[s];
        best = -1;
        bestd = 0;
        for (int i = 0; i < Slots; i++) begin
          k = s*Slots + i;
          if (frag_used[k]) begin
            d = frag_start[k] - e;
            if (best < 0 || d < bestd) begin
              best = i;
              bestd = d;
            end
          end
        end
        k = s*Slots + best;
        put(RK_DATA, s[0], 1, best[3:0], 0, frag_len[k], bestd, ST_HANDLED, 0, 0);
        next_seq[s] = frag_start[k] + frag_len[k];
        frag_used[k] = 0;
      end else if (!clean && ooo_limit > 0 && n > ooo_limit) begin
        clean = 1;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void shut(bit reason);
    if (!conn_open) return;
    settle_side(0, 1);
    settle_side(1, 1);
    for (int i = 0; i < 2*Slots; i++) frag_used[i] = 0;
    put(RK_CLOSE, 0, 0, 0, 0, 0, 0, ST_HANDLED, reason, 0);
    conn_open = 0;
    sides_seen = 0;
    side_done[0] = 0;
    side_done[1] = 0;
    last_side = NoSide;
  endfunction

  function automatic void finish_side(int s, bit is_rst);
    if (side_done[s]) return;
    side_done[s] = 1;
    if (side_done[1-s]) begin
      shut(RSN_FIN_RST);
      return;
    end
    settle_side(s, 1);
    if (is_rst) shut(RSN_FIN_RST);
  endfunction

  function automatic int slot_for(int s, bit [31:0] sq);
    int free_slot;
    free_slot = -1;
    for (int i = 0; i < Slots; i++) begin
      if (frag_used[s*Slots+i]) begin
        if (frag_start[s*Slots+i] == sq) return i;
      end else if (free_slot < 0) free_slot = i;
    end
    return free_slot;
  endfunction

  function automatic bit [3:0] take_segment(bit [1:0] pk, bit [31:0] addr, bit [15:0] port,
                                            bit [31:0] sq, bit [15:0] plen, bit syn,
                                            bit fin, bit rs);
    bit finrst, first;
    bit [31:0] len, e, skip;
    int s, slot, k;
    finrst = fin || rs;
    first = 0;
    len = plen;
    if (pk == PK_NON_TCP) return ST_NON_TCP;
    if (pk != PK_TCP) return ST_NON_IP;
    if (len == 0 && !syn && !finrst) return ST_NO_DATA;
    if (!conn_open) begin
      conn_open = 1;
      sides_seen = 0;
      side_done[0] = 0;
      side_done[1] = 0;
      last_side = NoSide;
      for (int i = 0; i < 2*Slots; i++) frag_used[i] = 0;
      put(RK_START, 0, 0, 0, 0, 0, 0, ST_HANDLED, 0, 0);
    end
    if (sides_seen == 0) begin
      s = 0; peer_addr[0] = addr; peer_port[0] = port; sides_seen = 1; first = 1;
    end else if (peer_addr[0] == addr && peer_port[0] == port) begin
      s = 0;
    end else if (sides_seen == 1) begin
      s = 1; peer_addr[1] = addr; peer_port[1] = port; sides_seen = 2; first = 1;
    end else if (peer_addr[1] == addr && peer_port[1] == port) begin
      s = 1;
    end else begin
      return ST_NO_MATCH;
    end

    if (side_done[s]) begin
      if (!side_done[1-s] && rs) begin
        finish_side(1-s, rs);
        return ST_FIN_RST;
      end
      return ST_CLOSED;
    end
    if (finrst && len == 0) begin
      finish_side(s, rs);
      return ST_FIN_RST;
    end
    if (clear_on_switch && !first && len > 0 && last_side != NoSide && last_side != s &&
        frags_held(last_side) > 0)
      settle_side(last_side, 1);
    last_side = s;

    if (first) begin
      next_seq[s] = sq + len + syn;
      if (len != 0) put(RK_DATA, s[0], 0, 0, 0, plen, 0, ST_HANDLED, 0, 0);
      if (finrst) finish_side(s, rs);
      return ST_HANDLED;
    end
    if ((sq - next_seq[s]) >= 32'h8000_0000) begin
      e = next_seq[s];
      if (!not_after(sq + len - e)) begin
        skip = e - sq;
        next_seq[s] = e + (len - skip);
        put(RK_DATA, s[0], 0, 0, skip[15:0], len[15:0] - skip[15:0], 0, ST_HANDLED, 0, 0);
        if (finrst) finish_side(s, rs);
        return ST_HANDLED;
      end
      if (finrst) finish_side(s, rs);
      return ST_RETRANS;
    end
    if (len == 0) begin
      if (finrst) begin
        finish_side(s, rs);
        return ST_FIN_RST;
      end
      return ST_NO_DATA;
    end
    if (sq == next_seq[s]) begin
      next_seq[s] = sq + len + syn;
      put(RK_DATA, s[0], 0, 0, 0, plen, 0, ST_HANDLED, 0, 0);
      settle_side(s, 0);
      if (finrst) finish_side(s, rs);
      return ST_HANDLED;
    end
    slot = slot_for(s, sq);
    if (slot < 0) begin
      settle_side(s, 1);
      slot = slot_for(s, sq);
      if (slot < 0) return ST_NO_MEM;
    end
    k = s*Slots + slot;
    frag_used[k] = 1;
    frag_start[k] = sq;
    frag_len[k] = plen;
    if (ooo_limit > 0 && frags_held(s) > ooo_limit) settle_side(s, 0);
    if (finrst) finish_side(s, rs);
    return ST_BUFFERED;
  endfunction

  task automatic check_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_on_switch = 0;
      ooo_limit = 0;
      conn_open = 0;
      sides_seen = 0;
      side_done[0] = 0;
      side_done[1] = 0;
      last_side = NoSide;
      for (int i = 0; i < 2*Slots; i++) frag_used[i] = 0;
      expected_results.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_CLEAR_ON_SWITCH) clear_on_switch = cfg_data[0];
        else ooo_limit = cfg_data;
      end
      if (in_valid && in_ready) begin
        bit [3:0] st;
        emitted = 0;
        if (operation) begin
          shut(RSN_MANUAL);
          st = ST_HANDLED;
        end else begin
          st = take_segment(packet_kind, source_address, source_port, segment_seq,
                            payload_length, syn_flag, fin_flag, rst_flag);
        end
        put(RK_STATUS, 0, 0, 0, 0, 0, 0, st, 0, 1);
      end
      if (out_valid && out_ready) begin
        result_t e;
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d status %0d", $realtime, result_kind,
                   status_code);
          failures++;
        end else begin
          e = expected_results.pop_front();
          check_field("result_kind", e.kind, result_kind);
          check_field("side", e.side, side);
          check_field("from_fragment", e.from_frag, from_fragment);
          check_field("slot_index", e.slot, slot_index);
          check_field("byte_offset", e.off, byte_offset);
          check_field("byte_count", e.cnt, byte_count);
          check_field("missing_bytes", e.miss, missing_bytes);
          check_field("status_code", e.status, status_code);
          check_field("close_reason", e.reason, close_reason);
          check_field("last", e.last, last);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Testbench top: clock, reset, stimulus phases and verdict for TCP stream reassembly.
`timescale 1ns / 100ps
module testbench;
  import tsr_pkg::*;

  localparam logic      OP_SEGMENT = 1'b0;
  localparam logic      OP_CLOSE   = 1'b1;
  localparam logic [1:0] PK_NON_IP = 2'd1;
  localparam logic [1:0] PK_ODD    = 2'd3;
  localparam int        CycleLimit = 1_000_000;

  logic        clk, rst;
  logic        cfg_write, cfg_index;
  logic [4:0]  cfg_data;
  logic        in_valid, in_ready, operation;
  logic [1:0]  packet_kind;
  logic [31:0] source_address, segment_seq;
  logic [15:0] source_port, payload_length;
  logic        syn_flag, fin_flag, rst_flag;
  logic        out_valid, out_ready;
  logic [1:0]  result_kind;
  logic        side, from_fragment, close_reason, last;
  logic [3:0]  slot_index, status_code;
  logic [15:0] byte_offset, byte_count;
  logic [31:0] missing_bytes;
  int          failures, pending, results_seen;

  int          send_idle_pct, recv_stall_pct;
  logic        long_hold;
  int          held_cycles, cycles, items_sent;

  bit [31:0]   ep_addr[2];
  bit [15:0]   ep_port[2];
  bit [31:0]   ep_next[2];

  tcp_stream_reassembly_top i_dut (.*);

  tsr_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** tcp_stream_reassembly_top: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      held_cycles <= 0;
    end else if (long_hold && held_cycles < 400) begin
      held_cycles <= held_cycles + 1;
      out_ready <= 0;
    end else begin
      if (!long_hold) held_cycles <= 0;
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic offer(logic op, logic [1:0] pk, logic [31:0] addr, logic [15:0] port,
                       logic [31:0] sq, logic [15:0] len, logic syn, logic fin,
                       logic rs);
    operation <= op; packet_kind <= pk; source_address <= addr; source_port <= port;
    segment_seq <= sq; payload_length <= len; syn_flag <= syn; fin_flag <= fin;
    rst_flag <= rs;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // the status result is the last one, but let the sequencer settle
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(bit clear_sw, bit [4:0] limit);
    cfg_write <= 1; cfg_index <= CFG_CLEAR_ON_SWITCH; cfg_data <= {4'd0, clear_sw};
    @(posedge clk);
    cfg_index <= CFG_MAX_OOO; cfg_data <= limit;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  task automatic new_peers();
    for (int s = 0; s < 2; s++) begin
      ep_addr[s] = $urandom();
      ep_port[s] = 16'($urandom());
      ep_next[s] = $urandom();
    end
  endtask

  // mostly well-formed traffic on the two peers, with holes, repeats and noise
  task automatic random_item();
    int r, s;
    bit [31:0] sq;
    bit [15:0] len;
    bit syn, fin, rs;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 1);
    syn = ($urandom_range(0, 99) < 5);
    fin = ($urandom_range(0, 99) < 3);
    rs  = ($urandom_range(0, 99) < 2);
    len = ($urandom_range(0, 99) < 3) ? 16'hFFFF :
          ($urandom_range(0, 99) < 4) ? 16'd0 : 16'($urandom_range(1, 40));
    if (r < 4) begin
      offer(OP_CLOSE, PK_TCP, $urandom(), 16'($urandom()), $urandom(), 16'($urandom()),
            0, 0, 0);
      if ($urandom_range(0, 1)) new_peers();
    end else if (r < 8) begin
      offer(OP_SEGMENT, 2'($urandom_range(1, 3)), $urandom(), 16'($urandom()), $urandom(),
            16'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
    end else if (r < 11) begin
      offer(OP_SEGMENT, PK_TCP, $urandom(), 16'($urandom()), $urandom(), len, syn, fin, rs);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        sq = ep_next[s];
        ep_next[s] = ep_next[s] + len + syn;
      end else if (r < 78) begin
        sq = ep_next[s] + $urandom_range(1, 80);
      end else begin
        sq = ep_next[s] - $urandom_range(0, 60);
      end
      offer(OP_SEGMENT, PK_TCP, ep_addr[s], ep_port[s], sq, len, syn, fin, rs);
      if (fin || rs) if ($urandom_range(0, 3) == 0) new_peers();
    end
  endtask

  task automatic random_phase(bit clear_sw, bit [4:0] limit, int idle, int stall,
                              bit with_hold);
    configure(clear_sw, limit);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    new_peers();
    for (int i = 0; i < 22; i++) begin
      if (with_hold && i == 2) long_hold <= 1;
      if (with_hold && i == 10) long_hold <= 0;
      random_item();
    end
    drain();
  endtask

  initial begin
    rst = 1;
    cfg_write = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; operation = 0; packet_kind = 0; source_address = 0; source_port = 0;
    segment_seq = 0; payload_length = 0; syn_flag = 0; fin_flag = 0; rst_flag = 0;
    long_hold = 0; cycles = 0; items_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    configure(0, 0);

    // directed: odd packet kinds, sequence wrap, overlap, third peer, FIN and RST
    offer(OP_CLOSE, PK_TCP, 0, 0, 0, 0, 0, 0, 0);
    offer(OP_SEGMENT, PK_NON_IP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, 1);
    offer(OP_SEGMENT, PK_ODD, 0, 0, 0, 0, 0, 0, 0);
    offer(OP_SEGMENT, PK_NON_TCP, 0, 0, 0, 10, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 0, 0, 0, 0, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF0, 0, 1, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 0, 0, 0, 10, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0005, 8, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0005, 12, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF1, 30, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF1, 5, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0075, 4, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_000E, 10, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'h0000_0001, 16'h0001, 32'h0000_0018, 4, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0018, 0, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 0, 0, 32'h0000_000A, 0, 0, 1, 0);
    offer(OP_SEGMENT, PK_TCP, 0, 0, 32'h0000_000A, 5, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0030, 6, 0, 1, 0);
    offer(OP_CLOSE, PK_TCP, 0, 0, 0, 0, 0, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'h1234_5678, 16'h8000, 0, 16'hFFFF, 0, 0, 1);
    offer(OP_SEGMENT, PK_TCP, 32'h1234_5678, 16'h8000, 32'h7FFF_FFFF, 20, 1, 0, 0);
    offer(OP_SEGMENT, PK_TCP, 32'h1234_5678, 16'h8000, 32'h8000_0040, 9, 0, 0, 0);
    offer(OP_CLOSE, PK_TCP, 0, 0, 0, 0, 0, 0, 0);
    drain();

    random_phase(1, 16, 0, 0, 0);
    random_phase(0, 1, 67, 0, 1);
    random_phase(1, 3, 0, 67, 0);
    random_phase(0, 0, 11, 11, 0);

    repeat (50) @(posedge clk);
    $display("Run covered %0d input transactions and %0d result transactions,", items_sent,
             results_seen);
    $display("over four register settings and stall mixes including a long hold-off.");
    if (failures == 0) begin
      $display("** tcp_stream_reassembly_top: PASSED **");
    end else begin
      $display("** tcp_stream_reassembly_top: FAILED **");
    end
    $finish;
  end

endmodule
